FILE: rtl/core/lpbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpbd_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int SID_W  = 32;

    localparam logic [OP_W-1:0] OP_DATA       = 2'd0;
    localparam logic [OP_W-1:0] OP_CONNECT    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd3;

    localparam logic [LEN_W-1:0] MIN_WIRE_LEN    = 16'd14;
    localparam logic [LEN_W-1:0] HEADER_BYTES    = 16'd2;
    localparam logic [LEN_W-1:0] MIN_LIMIT       = 16'd12;
    localparam logic [LEN_W-1:0] MAX_BLOCK_RESET = 16'd4096;

endpackage
`default_nettype wire

FILE: rtl/core/length_prefixed_block_deframer.sv
// length prefixed block deframer
// s_ channel: one item per cycle while s_ready is high, opcode plus data
// byte (data, connect, clear, disconnect). m_ channel: at most one result
// item per input item, either a body byte (last_in_block and block_length
// on the final byte) or a single length_error item for a bad header.
// cfg channel: cfg_data writes max_block_bytes; cfg_ready is always high.
// an accepted item is held in an input register, then processed by one
// level of compare and counter logic into the output register, which
// drives m_valid; the item waits while the output register is not free.
// throughput is one item per cycle unless the receiver stalls, set by the
// input/output register pair; the only feedback loop is the state update.
// while the receiver stalls, the output register holds its item and the
// input register still takes one more item; s_ready drops after that.
// items that give no result also wait for the output register to be free,
// so order is always kept.
// reset (aresetn low, synchronous) empties both registers, sets the stream
// number to 1, the link to down, header parsing to the length high byte and
// max_block_bytes to 4096. there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module length_prefixed_block_deframer (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [lpbd_pkg::OP_W-1:0]          s_opcode,
    input  wire  [lpbd_pkg::BYTE_W-1:0]        s_data_byte,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [lpbd_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_last_in_block,
    output logic [lpbd_pkg::LEN_W-1:0]         m_block_length,
    output logic                               m_length_error,
    output logic [lpbd_pkg::SID_W-1:0]         m_stream_number,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [lpbd_pkg::LEN_W-1:0]         cfg_data
);
    import lpbd_pkg::*;

    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic              in_valid_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic [LEN_W-1:0]  max_block_reg;
    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [SID_W-1:0]  sid_reg, sid_next;
    logic              link_reg, link_next;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_last_reg;
    logic [LEN_W-1:0]  m_len_reg;
    logic              m_err_reg;
    logic [SID_W-1:0]  m_sid_reg;

    logic              out_free;
    logic              advance;
    logic              emit;
    logic [BYTE_W-1:0] e_byte;
    logic              e_last;
    logic [LEN_W-1:0]  e_len;
    logic              e_err;

    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  limit;
    logic [LEN_W:0]    limit_hdr;
    logic              bad_len;
    logic [LEN_W-1:0]  left_dec;
    logic [SID_W-1:0]  sid_inc;
    logic [SID_W-1:0]  sid_adv;

    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign frame_len = {len_hi_reg, in_byte_reg};
    assign limit     = (max_block_reg < MIN_LIMIT) ? MIN_LIMIT : max_block_reg;
    assign limit_hdr = {1'b0, limit} + {1'b0, HEADER_BYTES};
    assign bad_len   = (frame_len < MIN_WIRE_LEN) || ({1'b0, frame_len} > limit_hdr);
    assign left_dec  = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
    assign sid_inc   = sid_reg + 1'b1;
    assign sid_adv   = (sid_inc == '0) ? {{(SID_W-1){1'b0}}, 1'b1} : sid_inc;

    always_comb begin
        phase_next  = phase_reg;
        len_hi_next = len_hi_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        sid_next    = sid_reg;
        link_next   = link_reg;
        emit        = 1'b0;
        e_byte      = '0;
        e_last      = 1'b0;
        e_len       = '0;
        e_err       = 1'b0;
        if (in_op_reg != OP_DATA) begin
            phase_next  = PH_LEN_HI;
            len_hi_next = '0;
            left_next   = '0;
            total_next  = '0;
            sid_next    = sid_adv;
            if (in_op_reg == OP_CONNECT) begin
                link_next = 1'b1;
            end else if (in_op_reg == OP_DISCONNECT) begin
                link_next = 1'b0;
            end
        end else if (link_reg) begin
            case (phase_reg)
                PH_LEN_LO: begin
                    if (bad_len) begin
                        emit        = 1'b1;
                        e_err       = 1'b1;
                        link_next   = 1'b0;
                        phase_next  = PH_LEN_HI;
                        len_hi_next = '0;
                        left_next   = '0;
                        total_next  = '0;
                        sid_next    = sid_adv;
                    end else begin
                        total_next = frame_len - HEADER_BYTES;
                        left_next  = frame_len - HEADER_BYTES;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    emit      = 1'b1;
                    left_next = left_dec;
                    e_byte    = in_byte_reg;
                    e_last    = (left_dec == '0);
                    e_len     = (left_dec == '0) ? total_reg : '0;
                    if (left_dec == '0) begin
                        phase_next = PH_LEN_HI;
                    end
                end
                default: begin
                    len_hi_next = in_byte_reg;
                    phase_next  = PH_LEN_LO;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            max_block_reg <= MAX_BLOCK_RESET;
            phase_reg     <= PH_LEN_HI;
            len_hi_reg    <= '0;
            left_reg      <= '0;
            total_reg     <= '0;
            sid_reg       <= {{(SID_W-1){1'b0}}, 1'b1};
            link_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_block_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg   <= phase_next;
                len_hi_reg  <= len_hi_next;
                left_reg    <= left_next;
                total_reg   <= total_next;
                sid_reg     <= sid_next;
                link_reg    <= link_next;
                m_valid_reg <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_opcode;
            in_byte_reg <= s_data_byte;
        end
        if (advance && emit) begin
            m_byte_reg <= e_byte;
            m_last_reg <= e_last;
            m_len_reg  <= e_len;
            m_err_reg  <= e_err;
            m_sid_reg  <= sid_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_last_in_block = m_last_reg;
    assign m_block_length  = m_len_reg;
    assign m_length_error  = m_err_reg;
    assign m_stream_number = m_sid_reg;

endmodule
`default_nettype wire

FILE: verif/length_prefixed_block_deframer_test.sv
`timescale 1ns / 1ps
module length_prefixed_block_deframer_test;
    import lpbd_pkg::*;

    typedef enum logic [1:0] {PH_LEN_HI = 2'd0, PH_LEN_LO = 2'd1, PH_BODY = 2'd2} hdr_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_in_block;
        logic [LEN_W-1:0]  block_length;
        logic              length_error;
        logic [SID_W-1:0]  stream_number;
    } deframe_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        bit                typed;
        bit                yields;
        deframe_result_t   res;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [OP_W-1:0]   s_opcode;
    logic [BYTE_W-1:0] s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last_in_block;
    logic [LEN_W-1:0]  m_block_length;
    logic              m_length_error;
    logic [SID_W-1:0]  m_stream_number;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data;

    // tracked copy of the deframer state
    hdr_phase_t        trk_phase;
    logic [7:0]        trk_len_hi;
    logic [15:0]       trk_left;
    logic [15:0]       trk_total;
    logic [31:0]       trk_stream;
    logic              trk_link;
    logic [15:0]       trk_max;

    deframe_result_t   pending_deframed[$];
    stim_row_t         directed_rows[26];
    logic [15:0]       limit_plan[8];

    int unsigned       send_gap_pct;
    int unsigned       recv_stall_pct;
    int unsigned       items_counted;
    int unsigned       fail_count;
    int unsigned       n_results;
    int unsigned       n_block_ends;
    int unsigned       n_len_errors;

    length_prefixed_block_deframer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_in_block (m_last_in_block),
        .m_block_length  (m_block_length),
        .m_length_error  (m_length_error),
        .m_stream_number (m_stream_number),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        deframe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (m_last_in_block) n_block_ends++;
            if (m_length_error) n_len_errors++;
            if (pending_deframed.size() == 0) begin
                $error("unexpected result item: out_byte %0h stream %0d",
                       m_out_byte, m_stream_number);
                fail_count++;
            end else begin
                want = pending_deframed.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("out_byte expected %0h actual %0h", want.out_byte, m_out_byte);
                    fail_count++;
                end
                if (m_last_in_block !== want.last_in_block) begin
                    $error("last_in_block expected %0d actual %0d",
                           want.last_in_block, m_last_in_block);
                    fail_count++;
                end
                if (m_block_length !== want.block_length) begin
                    $error("block_length expected %0d actual %0d",
                           want.block_length, m_block_length);
                    fail_count++;
                end
                if (m_length_error !== want.length_error) begin
                    $error("length_error expected %0d actual %0d",
                           want.length_error, m_length_error);
                    fail_count++;
                end
                if (m_stream_number !== want.stream_number) begin
                    $error("stream_number expected %0d actual %0d",
                           want.stream_number, m_stream_number);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("[length_prefixed_block_deframer] ERROR");
        $finish;
    end

    task automatic next_stream();
        trk_phase  = PH_LEN_HI;
        trk_len_hi = '0;
        trk_left   = '0;
        trk_total  = '0;
        trk_stream = trk_stream + 32'd1;
        if (trk_stream == 32'd0) trk_stream = 32'd1;
    endtask

    task automatic deframe_step(input logic [OP_W-1:0] op, input logic [7:0] b,
                                output bit produced, output deframe_result_t res);
        logic [15:0] hdr_len;
        logic [17:0] ceiling;
        produced = 1'b0;
        res = '0;
        case (op)
            OP_CONNECT: begin
                trk_link = 1'b1;
                next_stream();
            end
            OP_CLEAR: begin
                next_stream();
            end
            OP_DISCONNECT: begin
                trk_link = 1'b0;
                next_stream();
            end
            default: begin
                if (trk_link) begin
                    case (trk_phase)
                        PH_LEN_LO: begin
                            hdr_len = {trk_len_hi, b};
                            ceiling = 18'(trk_max < MIN_LIMIT ? MIN_LIMIT : trk_max)
                                      + 18'(HEADER_BYTES);
                            if (hdr_len < MIN_WIRE_LEN || 18'(hdr_len) > ceiling) begin
                                produced = 1'b1;
                                res.length_error = 1'b1;
                                res.stream_number = trk_stream;
                                trk_link = 1'b0;
                                next_stream();
                            end else begin
                                trk_total = hdr_len - HEADER_BYTES;
                                trk_left  = trk_total;
                                trk_phase = PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            if (trk_left != 0) trk_left--;
                            produced = 1'b1;
                            res.out_byte = b;
                            res.last_in_block = (trk_left == 0);
                            res.block_length = (trk_left == 0) ? trk_total : 16'd0;
                            res.stream_number = trk_stream;
                            if (trk_left == 0) trk_phase = PH_LEN_HI;
                        end
                        default: begin
                            trk_len_hi = b;
                            trk_phase  = PH_LEN_LO;
                        end
                    endcase
                end
            end
        endcase
    endtask

    task automatic push_item(input logic [OP_W-1:0] op, input logic [7:0] b,
                             input bit typed = 1'b0, input bit yields = 1'b0,
                             input deframe_result_t typed_res = '0);
        bit produced;
        deframe_result_t res;
        @(negedge aclk);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != OP_DATA || trk_link) items_counted++;
        deframe_step(op, b, produced, res);
        if (typed) begin
            if (yields) pending_deframed.push_back(typed_res);
        end else if (produced) begin
            pending_deframed.push_back(res);
        end
    endtask

    task automatic write_max_block(input logic [15:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_deframed.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        trk_max = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_block();
        int unsigned lim;
        int unsigned top;
        int unsigned pick;
        int unsigned hdr;
        int unsigned body;
        int unsigned cut;
        logic [OP_W-1:0] ev;
        logic [15:0] hdr_bits;
        lim  = 32'((trk_max < MIN_LIMIT) ? MIN_LIMIT : trk_max);
        top  = (lim + 2 > 65535) ? 65535 : lim + 2;
        pick = $urandom_range(99);
        ev   = OP_W'($urandom_range(3, 1));
        if (pick < 70) hdr = $urandom_range((top > 40) ? 40 : top, 14);
        else if (pick < 80) hdr = top;
        else if (pick < 89) hdr = $urandom_range(13, 0);
        else if (lim + 3 <= 65535)
            hdr = ($urandom_range(1)) ? lim + 3 : $urandom_range(65535, lim + 3);
        else hdr = 65535;
        hdr_bits = hdr[15:0];
        push_item(OP_DATA, hdr_bits[15:8]);
        // header cut after its high byte
        if ($urandom_range(99) < 4) begin
            push_item(ev, 8'($urandom_range(255)));
            return;
        end
        push_item(OP_DATA, hdr_bits[7:0]);
        if (hdr < 14 || hdr > lim + 2) return;
        body = hdr - 2;
        cut  = body;
        if (body > 48) cut = $urandom_range(8, 0);
        else if ($urandom_range(99) < 12) cut = $urandom_range(body - 1, 0);
        for (int unsigned k = 0; k < cut; k++) push_item(OP_DATA, 8'($urandom_range(255)));
        if (cut < body) push_item(ev, 8'($urandom_range(255)));
    endtask

    initial begin
        int unsigned target;
        logic [OP_W-1:0] op;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = OP_DATA;
        s_data_byte    = '0;
        m_ready        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        items_counted  = 0;
        fail_count     = 0;
        n_results      = 0;
        n_block_ends   = 0;
        n_len_errors   = 0;
        trk_phase      = PH_LEN_HI;
        trk_len_hi     = '0;
        trk_left       = '0;
        trk_total      = '0;
        trk_stream     = 32'd1;
        trk_link       = 1'b0;
        trk_max        = MAX_BLOCK_RESET;

        directed_rows = '{
            '{OP_DATA,       8'hFF, 1'b1, 1'b0, '0},
            '{OP_DISCONNECT, 8'h00, 1'b1, 1'b0, '0},
            '{OP_CONNECT,    8'hFF, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'h00, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'h0D, 1'b1, 1'b1, '{8'h00, 1'b0, 16'd0, 1'b1, 32'd3}},
            '{OP_CONNECT,    8'h00, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'h10, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'h03, 1'b1, 1'b1, '{8'h00, 1'b0, 16'd0, 1'b1, 32'd5}},
            '{OP_CONNECT,    8'h00, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'h00, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'h0E, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'h00, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'hFF, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h01, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h80, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h7F, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h55, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'hAA, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'hFE, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h02, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h40, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h20, 1'b0, 1'b0, '0},
            '{OP_DATA,       8'h81, 1'b1, 1'b1, '{8'h81, 1'b1, 16'd12, 1'b0, 32'd7}},
            '{OP_CLEAR,      8'hFF, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'hFF, 1'b1, 1'b0, '0},
            '{OP_DATA,       8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 16'd0, 1'b1, 32'd8}}
        };
        limit_plan = '{16'd12, 16'd0, 16'hFFFF, 16'd20, 16'hFFFE, 16'd11, 16'd65533, 16'd4096};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            push_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                      directed_rows[i].yields, directed_rows[i].res);
        end

        for (int p = 0; p < 8; p++) begin
            write_max_block(limit_plan[p]);
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 78; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 78; end
                default: begin send_gap_pct = 18; recv_stall_pct = 18; end
            endcase
            target = items_counted + 105;
            while (items_counted < target) begin
                if (!trk_link) begin
                    op = ($urandom_range(9) < 8) ? OP_CONNECT : OP_W'($urandom_range(3));
                    push_item(op, 8'($urandom_range(255)));
                end else if ($urandom_range(99) < 6) begin
                    op = OP_W'($urandom_range(3, 1));
                    push_item(op, 8'($urandom_range(255)));
                end else begin
                    send_block();
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_deframed.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d input items over the reset limit, 8 written limits, 4 idle patterns",
                 items_counted);
        $display("checked %0d result items: %0d complete blocks, %0d length errors",
                 n_results, n_block_ends, n_len_errors);
        if (fail_count == 0) begin
            $display("[length_prefixed_block_deframer] OK");
        end else begin
            $display("[length_prefixed_block_deframer] ERROR");
        end
        $finish;
    end
endmodule
